>>> rtl/ssf_pkg.sv
package ssf_pkg;

    // Default sizes of the tables and of one fan-out run, and the stored destination width
    localparam int AXON_COUNT_DEF   = 256;
    localparam int WEIGHT_DEPTH_DEF = 4096;
    localparam int MAX_BLOCK_DEF    = 64;
    localparam int DEST_BITS_DEF    = 16;

    // Fixed field widths of the command and result words
    localparam int COMMAND_W = 2;
    localparam int INDEX_W   = 12;
    localparam int BASE_W    = 12;
    localparam int SIZE_W    = 7;
    localparam int DEST_W    = 16;
    localparam int WEIGHT_W  = 16;
    localparam int AXON_W    = 8;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_WRITE_OFFSET = 2'd0,
        CMD_WRITE_WEIGHT = 2'd1,
        CMD_SPIKE        = 2'd2,
        CMD_UNUSED       = 2'd3
    } command_t;

endpackage

>>> rtl/ssf_ram.sv
module ssf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/spike_synapse_fanout.sv
// channel   direction  handshake                  word
// command   in         start & !busy              command, table_index, base_value,
//                                                 size_value, dest_value, weight_value, axon_id
// result    out        result_valid (one cycle)   dest_id, weight, last_flag
//
// Table writes complete without raising busy.
// A spike runs an offset read, the lookup, base reduction (one subtract of
// WEIGHT_DEPTH per cycle, none when the depth is at least 4096), then one
// weight-memory read per synapse; each result appears in the cycle after its read.
// Size zero ends after the lookup. rst_n clears control only; both tables are
// undefined until written. Results cannot be held off.
module spike_synapse_fanout #(
    parameter int AXON_COUNT   = ssf_pkg::AXON_COUNT_DEF,
    parameter int WEIGHT_DEPTH = ssf_pkg::WEIGHT_DEPTH_DEF,
    parameter int MAX_BLOCK    = ssf_pkg::MAX_BLOCK_DEF,
    parameter int DEST_BITS    = ssf_pkg::DEST_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ssf_pkg::COMMAND_W-1:0]       command,
    input  logic [ssf_pkg::INDEX_W-1:0]         table_index,
    input  logic [ssf_pkg::BASE_W-1:0]          base_value,
    input  logic [ssf_pkg::SIZE_W-1:0]          size_value,
    input  logic [ssf_pkg::DEST_W-1:0]          dest_value,
    input  logic signed [ssf_pkg::WEIGHT_W-1:0] weight_value,
    input  logic [ssf_pkg::AXON_W-1:0]          axon_id,
    output logic                                result_valid,
    output logic [ssf_pkg::DEST_W-1:0]          dest_id,
    output logic signed [ssf_pkg::WEIGHT_W-1:0] weight,
    output logic                                last_flag
);

    import ssf_pkg::*;

    localparam int OAW      = (AXON_COUNT > 1) ? $clog2(AXON_COUNT) : 1;
    localparam int WAW      = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int CW       = $clog2(MAX_BLOCK + 1);
    localparam int OFS_W    = BASE_W + SIZE_W;
    localparam int WT_W     = DEST_BITS + WEIGHT_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_WALK   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [WAW-1:0]    addr_reg, addr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              valid_reg, valid_next;
    logic              last_reg, last_next;

    logic              accept;
    command_t          cmd;
    logic [SIZE_W-1:0] size_sat;
    logic              ofs_wr_en, wt_wr_en, ofs_rd_en, wt_rd_en;
    logic [OAW-1:0]    ofs_wr_addr, ofs_rd_addr;
    logic [WAW-1:0]    wt_wr_addr;
    logic [OFS_W-1:0]  ofs_rd_data;
    logic [WT_W-1:0]   wt_wr_data, wt_rd_data;
    logic [31:0]       dest_in_ext, dest_out_ext, index_ext, axon_ext;
    logic [SIZE_W-1:0] look_size;
    logic              last_issue;

    assign accept = start && !busy;
    assign cmd    = command_t'(command);
    assign busy   = (state_reg != ST_IDLE);

    assign index_ext   = 32'(table_index);
    assign axon_ext    = 32'(axon_id);
    assign dest_in_ext = 32'(dest_value);

    // size saturates on write
    assign size_sat = (32'(size_value) > 32'(MAX_BLOCK)) ? SIZE_W'(MAX_BLOCK) : size_value;

    assign ofs_wr_en   = accept && (cmd == CMD_WRITE_OFFSET) && (index_ext < 32'(AXON_COUNT));
    assign ofs_wr_addr = index_ext[OAW-1:0];
    assign ofs_rd_en   = accept && (cmd == CMD_SPIKE) && (axon_ext < 32'(AXON_COUNT));
    assign ofs_rd_addr = axon_ext[OAW-1:0];

    assign wt_wr_en   = accept && (cmd == CMD_WRITE_WEIGHT) && (index_ext < 32'(WEIGHT_DEPTH));
    assign wt_wr_addr = index_ext[WAW-1:0];
    assign wt_wr_data = {weight_value, dest_in_ext[DEST_BITS-1:0]};
    assign wt_rd_en   = (state_reg == ST_WALK);

    ssf_ram #(
        .WIDTH (OFS_W),
        .DEPTH (AXON_COUNT)
    ) u_offset_ram (
        .clk     (clk),
        .wr_en   (ofs_wr_en),
        .wr_addr (ofs_wr_addr),
        .wr_data ({size_sat, base_value}),
        .rd_en   (ofs_rd_en),
        .rd_addr (ofs_rd_addr),
        .rd_data (ofs_rd_data)
    );

    ssf_ram #(
        .WIDTH (WT_W),
        .DEPTH (WEIGHT_DEPTH)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (wt_wr_en),
        .wr_addr (wt_wr_addr),
        .wr_data (wt_wr_data),
        .rd_en   (wt_rd_en),
        .rd_addr (addr_reg),
        .rd_data (wt_rd_data)
    );

    assign look_size  = ofs_rd_data[OFS_W-1:BASE_W];
    assign last_issue = (32'(count_reg) + 32'd1 == 32'(size_reg));

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        size_next  = size_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        valid_next = 1'b0;
        last_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ofs_rd_en)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                base_next  = ofs_rd_data[BASE_W-1:0];
                size_next  = (32'(look_size) > 32'(MAX_BLOCK)) ? SIZE_W'(MAX_BLOCK)
                                                               : look_size;
                count_next = '0;
                state_next = (look_size == '0) ? ST_IDLE : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // base modulo table depth, one subtract a cycle
                if (32'(base_reg) >= 32'(WEIGHT_DEPTH))
                begin
                    base_next = base_reg - BASE_W'(WEIGHT_DEPTH);
                end
                else
                begin
                    addr_next  = WAW'(32'(base_reg));
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                valid_next = 1'b1;
                last_next  = last_issue;
                count_next = count_reg + CW'(1);
                addr_next  = (32'(addr_reg) == 32'(WEIGHT_DEPTH - 1)) ? '0 : addr_reg + WAW'(1);
                if (last_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            count_reg <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        size_reg <= size_next;
    end

    assign dest_out_ext = 32'(wt_rd_data[DEST_BITS-1:0]);
    assign result_valid = valid_reg;
    assign dest_id      = dest_out_ext[DEST_W-1:0];
    assign weight       = wt_rd_data[DEST_BITS +: WEIGHT_W];
    assign last_flag    = last_reg;

endmodule
